// ----- rtl/core/nec_tx_pkg.sv -----
// ----------------------------------------------------------------------------
// nec_tx_pkg
// Shared types and constants for the NEC frame transmitter: field widths,
// frame phase codes and protocol unit counts.
// ----------------------------------------------------------------------------
package nec_tx_pkg;

  localparam int CODE_W  = 8;
  localparam int UNITS_W = 5;
  localparam int PHASE_W = 3;
  localparam int BITPOS_W = 6;
  localparam int FRAME_W = 32;

  typedef logic [CODE_W-1:0]   code_t;
  typedef logic [UNITS_W-1:0]  units_t;
  typedef logic [PHASE_W-1:0]  phase_t;
  typedef logic [BITPOS_W-1:0] bitpos_t;
  typedef logic [FRAME_W-1:0]  frame_t;

  // Item kinds on the input channel
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // Frame phase codes
  localparam phase_t PH_IDLE      = 3'd0;
  localparam phase_t PH_LEAD_LOW  = 3'd1;
  localparam phase_t PH_LEAD_HIGH = 3'd2;
  localparam phase_t PH_BIT_LOW   = 3'd3;
  localparam phase_t PH_BIT_HIGH  = 3'd4;
  localparam phase_t PH_TRAILER   = 3'd5;

  // Codes and reset values
  localparam code_t NO_BUTTON     = 8'hFF;
  localparam code_t ADDRESS_RESET = 8'hB9;

  // Phase lengths in time units
  localparam units_t LEAD_LOW_UNITS         = 5'd16;
  localparam units_t LEAD_HIGH_FULL_UNITS   = 5'd8;
  localparam units_t LEAD_HIGH_REPEAT_UNITS = 5'd4;
  localparam units_t ONE_HIGH_UNITS         = 5'd3;
  localparam units_t SINGLE_UNIT            = 5'd1;

endpackage

// ----- rtl/core/nec_tx_ifs.sv -----
// ----------------------------------------------------------------------------
// nec_tx_ifs
// Valid/ready channel interfaces for the NEC frame transmitter: the input
// channel (ticks and requests) and the result channel.
// ----------------------------------------------------------------------------
interface nec_tx_in_if;
  import nec_tx_pkg::*;

  logic  valid;
  logic  ready;
  logic  kind;
  code_t command;

  modport source (output valid, output kind, output command, input ready);
  modport sink   (input valid, input kind, input command, output ready);
endinterface

interface nec_tx_out_if;
  logic valid;
  logic ready;
  logic line_low;
  logic busy_res;
  logic dropped;

  modport source (output valid, output line_low, output busy_res, output dropped,
                  input ready);
  modport sink   (input valid, input line_low, input busy_res, input dropped,
                  output ready);
endinterface

// ----- rtl/core/nec_frame_transmitter_with_repeat_top.sv -----
// ----------------------------------------------------------------------------
// nec_frame_transmitter_with_repeat_top
// NEC infrared frame transmitter with repeat frames, driven by unit ticks.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one transaction per tick (kind 0, one NEC time unit) or
//   per command request (kind 1, with command). Every input transaction
//   gives exactly one transaction on out_ch: the line level for that unit,
//   the busy flag and a dropped flag for requests that hit a running frame.
//   cfg_we/cfg_wdata write the device address; a full frame takes the
//   address when it starts.
// Throughput:
//   One transaction per cycle sustained while out_ch.ready is high. The frame
//   sequencer state and the result are updated in a single registered
//   stage, so the next item may enter in the following cycle.
// Reset:
//   rst_n (synchronous, active low) returns the sequencer to idle, the last
//   code to 255 (no button), the address to 0xB9 and empties the result
//   register.
// Stalls:
//   While a result waits in the output register and out_ch.ready is low,
//   in_ch.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module nec_frame_transmitter_with_repeat_top (
  input  logic                  clk,
  input  logic                  rst_n,
  nec_tx_in_if.sink             in_ch,
  nec_tx_out_if.source          out_ch,
  input  logic                  cfg_we,
  input  nec_tx_pkg::code_t     cfg_wdata
);
  import nec_tx_pkg::*;

  // Sequencer state
  code_t   device_address_r, device_address_nxt;
  frame_t  frame_bits_r, frame_bits_nxt;
  bitpos_t bit_position_r, bit_position_nxt;
  phase_t  frame_phase_r, frame_phase_nxt;
  units_t  units_left_r, units_left_nxt;
  logic    repeat_frame_r, repeat_frame_nxt;
  code_t   previous_code_r, previous_code_nxt;

  // Result register
  logic out_valid_r, out_valid_nxt;
  logic line_low_r, line_low_nxt;
  logic busy_res_r, busy_res_nxt;
  logic dropped_r, dropped_nxt;

  logic    in_fire;
  logic    active;
  logic    cur_bit;
  bitpos_t bit_pos_inc;

  // Accept while the result register is empty or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign active = (frame_phase_r == PH_LEAD_LOW)  || (frame_phase_r == PH_LEAD_HIGH) ||
                  (frame_phase_r == PH_BIT_LOW)   || (frame_phase_r == PH_BIT_HIGH)  ||
                  (frame_phase_r == PH_TRAILER);

  assign cur_bit     = frame_bits_r[bit_position_r[4:0]];
  assign bit_pos_inc = bit_position_r + bitpos_t'(1);

  // Address register
  always_comb begin
    device_address_nxt = cfg_we ? cfg_wdata : device_address_r;
  end

  // Next state and result for one accepted transaction
  always_comb begin
    frame_bits_nxt    = frame_bits_r;
    bit_position_nxt  = bit_position_r;
    frame_phase_nxt   = frame_phase_r;
    units_left_nxt    = units_left_r;
    repeat_frame_nxt  = repeat_frame_r;
    previous_code_nxt = previous_code_r;
    line_low_nxt      = line_low_r;
    busy_res_nxt      = busy_res_r;
    dropped_nxt       = dropped_r;

    if (in_fire) begin
      line_low_nxt = 1'b0;
      busy_res_nxt = 1'b0;
      dropped_nxt  = 1'b0;
      if (in_ch.kind == KIND_TICK) begin
        if (active) begin
          line_low_nxt = (frame_phase_r == PH_LEAD_LOW) || (frame_phase_r == PH_BIT_LOW) ||
                         (frame_phase_r == PH_TRAILER);
          busy_res_nxt = 1'b1;
          if (units_left_r <= SINGLE_UNIT) begin
            // Advance to the next phase
            unique case (frame_phase_r)
              PH_LEAD_LOW: begin
                frame_phase_nxt = PH_LEAD_HIGH;
                units_left_nxt  = repeat_frame_r ? LEAD_HIGH_REPEAT_UNITS
                                                 : LEAD_HIGH_FULL_UNITS;
              end
              PH_LEAD_HIGH: begin
                frame_phase_nxt = repeat_frame_r ? PH_TRAILER : PH_BIT_LOW;
                units_left_nxt  = SINGLE_UNIT;
              end
              PH_BIT_LOW: begin
                frame_phase_nxt = PH_BIT_HIGH;
                units_left_nxt  = cur_bit ? ONE_HIGH_UNITS : SINGLE_UNIT;
              end
              PH_BIT_HIGH: begin
                bit_position_nxt = bit_pos_inc;
                frame_phase_nxt  = bit_pos_inc[BITPOS_W-1] ? PH_TRAILER : PH_BIT_LOW;
                units_left_nxt   = SINGLE_UNIT;
              end
              default: begin
                frame_phase_nxt = PH_IDLE;
                units_left_nxt  = '0;
              end
            endcase
          end else begin
            units_left_nxt = units_left_r - SINGLE_UNIT;
          end
        end else begin
          frame_phase_nxt = PH_IDLE;
        end
      end else if (active) begin
        // Drop a request that arrives during a frame
        busy_res_nxt = 1'b1;
        dropped_nxt  = 1'b1;
      end else begin
        frame_phase_nxt = PH_IDLE;
        if (in_ch.command != NO_BUTTON) begin
          repeat_frame_nxt = (in_ch.command == previous_code_r);
          frame_bits_nxt   = {~in_ch.command, in_ch.command,
                              ~device_address_r, device_address_r};
          bit_position_nxt = '0;
          frame_phase_nxt  = PH_LEAD_LOW;
          units_left_nxt   = LEAD_LOW_UNITS;
          busy_res_nxt     = 1'b1;
        end
        previous_code_nxt = in_ch.command;
      end
    end
  end

  // Hold the result until the receiver takes it
  always_comb begin
    out_valid_nxt = in_fire || (out_valid_r && !out_ch.ready);
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r <= ADDRESS_RESET;
      frame_bits_r     <= '0;
      bit_position_r   <= '0;
      frame_phase_r    <= PH_IDLE;
      units_left_r     <= '0;
      repeat_frame_r   <= 1'b0;
      previous_code_r  <= NO_BUTTON;
      out_valid_r      <= 1'b0;
    end else begin
      device_address_r <= device_address_nxt;
      frame_bits_r     <= frame_bits_nxt;
      bit_position_r   <= bit_position_nxt;
      frame_phase_r    <= frame_phase_nxt;
      units_left_r     <= units_left_nxt;
      repeat_frame_r   <= repeat_frame_nxt;
      previous_code_r  <= previous_code_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    line_low_r <= line_low_nxt;
    busy_res_r <= busy_res_nxt;
    dropped_r  <= dropped_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.line_low = line_low_r;
  assign out_ch.busy_res = busy_res_r;
  assign out_ch.dropped  = dropped_r;

  // A dropped request is only reported while a frame is running
  a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dropped_r |-> busy_res_r)
    else $error("dropped reported without busy");

  // A request while idle with a real code starts a frame
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_ch.kind == KIND_REQUEST) && !active && (in_ch.command != NO_BUTTON)
    |=> (frame_phase_r == PH_LEAD_LOW) && (units_left_r == LEAD_LOW_UNITS))
    else $error("frame did not start on request");

  // A running phase always has units left
  a_units_left: assert property (@(posedge clk) disable iff (!rst_n)
    active |-> (units_left_r != '0))
    else $error("active phase with no units left");

endmodule

// ----- bench/nec_frame_transmitter_with_repeat_top_tb.sv -----
// ----------------------------------------------------------------------------
// nec_frame_transmitter_with_repeat_top_tb
// Self-checking bench for the NEC frame transmitter. A behavioral copy of
// the frame sequencer predicts line level, busy and dropped flags for every
// tick and request. Directed tests cover idle items, full frames, repeat
// frames, dropped requests and address hold, then random frames and noise
// run with random gaps on both channels and address changes between phases.
// ----------------------------------------------------------------------------
module nec_frame_transmitter_with_repeat_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nec_tx_pkg::*;

  localparam int ITEM_TARGET   = 1650;
  localparam int CFG_INTERVAL  = 300;
  localparam int REPEAT_UNITS  = 21;

  typedef struct packed {
    logic line_low;
    logic busy_res;
    logic dropped;
  } unit_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  code_t cfg_wdata;

  nec_tx_in_if  in_ch ();
  nec_tx_out_if out_ch ();

  nec_frame_transmitter_with_repeat_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Sequencer copy used for prediction
  frame_t  seq_bits;
  bitpos_t seq_bitpos;
  phase_t  seq_phase;
  units_t  seq_units;
  logic    seq_repeat;
  code_t   seq_last_code;
  code_t   seq_address;

  unit_result_t unit_results_due[$];
  int errors;
  int items_sent;
  bit no_gaps;

  // Stimulus-side bookkeeping: units left in the frame being sent
  code_t gen_address;
  code_t gen_last_code;
  int    gen_frame_left;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Advance the sequencer copy by one transaction and return its result
  function automatic unit_result_t predict_unit_result(logic kind, code_t cmd);
    unit_result_t r;
    logic running;
    r = '0;
    running = (seq_phase >= PH_LEAD_LOW) && (seq_phase <= PH_TRAILER);
    if (kind == KIND_TICK) begin
      if (running) begin
        r.line_low = (seq_phase == PH_LEAD_LOW) || (seq_phase == PH_BIT_LOW) ||
                     (seq_phase == PH_TRAILER);
        r.busy_res = 1'b1;
        if (seq_units <= SINGLE_UNIT) begin
          case (seq_phase)
            PH_LEAD_LOW: begin
              seq_phase = PH_LEAD_HIGH;
              seq_units = seq_repeat ? LEAD_HIGH_REPEAT_UNITS : LEAD_HIGH_FULL_UNITS;
            end
            PH_LEAD_HIGH: begin
              seq_phase = seq_repeat ? PH_TRAILER : PH_BIT_LOW;
              seq_units = SINGLE_UNIT;
            end
            PH_BIT_LOW: begin
              seq_phase = PH_BIT_HIGH;
              seq_units = seq_bits[seq_bitpos[4:0]] ? ONE_HIGH_UNITS : SINGLE_UNIT;
            end
            PH_BIT_HIGH: begin
              seq_bitpos = seq_bitpos + 1'b1;
              seq_phase  = (seq_bitpos >= FRAME_W) ? PH_TRAILER : PH_BIT_LOW;
              seq_units  = SINGLE_UNIT;
            end
            default: begin
              seq_phase = PH_IDLE;
              seq_units = '0;
            end
          endcase
        end else begin
          seq_units = seq_units - 1'b1;
        end
      end else begin
        seq_phase = PH_IDLE;
      end
    end else if (running) begin
      r.busy_res = 1'b1;
      r.dropped  = 1'b1;
    end else begin
      seq_phase = PH_IDLE;
      if (cmd != NO_BUTTON) begin
        seq_repeat = (cmd == seq_last_code);
        seq_bits   = {~cmd, cmd, ~seq_address, seq_address};
        seq_bitpos = '0;
        seq_phase  = PH_LEAD_LOW;
        seq_units  = LEAD_LOW_UNITS;
        r.busy_res = 1'b1;
      end
      seq_last_code = cmd;
    end
    return r;
  endfunction

  // Units in a full frame for a given address and code
  function automatic int full_frame_units(code_t addr, code_t cmd);
    frame_t bits;
    int n;
    bits = {~cmd, cmd, ~addr, addr};
    n = LEAD_LOW_UNITS + LEAD_HIGH_FULL_UNITS + 1;
    for (int i = 0; i < FRAME_W; i++) n += bits[i] ? 4 : 2;
    return n;
  endfunction

  // Predict accepted inputs, check accepted results, track address writes
  always @(posedge clk) begin
    unit_result_t want;
    unit_result_t got;
    if (!rst_n) begin
      seq_bits      = '0;
      seq_bitpos    = '0;
      seq_phase     = PH_IDLE;
      seq_units     = '0;
      seq_repeat    = 1'b0;
      seq_last_code = NO_BUTTON;
      seq_address   = ADDRESS_RESET;
    end else begin
      if (in_ch.valid && in_ch.ready)
        unit_results_due.push_back(predict_unit_result(in_ch.kind, in_ch.command));
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.line_low, out_ch.busy_res, out_ch.dropped};
        if (unit_results_due.size() == 0) begin
          $error("result transaction with none expected");
          errors++;
        end else begin
          want = unit_results_due.pop_front();
          if (got.line_low !== want.line_low) begin
            $error("line_low: expected %0b, got %0b", want.line_low, got.line_low);
            errors++;
          end
          if (got.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
            errors++;
          end
          if (got.dropped !== want.dropped) begin
            $error("dropped: expected %0b, got %0b", want.dropped, got.dropped);
            errors++;
          end
        end
      end
      if (cfg_we) seq_address = cfg_wdata;
    end
  end

  // Result side: random stalls before each transaction, none while no_gaps is set
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 3);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Send one transaction after a random gap; returns just after acceptance
  task automatic send_item(logic kind, code_t cmd);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.command <= cmd;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    // track frame length so ticks can be sized to frames
    if (kind == KIND_TICK) begin
      if (gen_frame_left > 0) gen_frame_left--;
    end else if (gen_frame_left == 0) begin
      if (cmd != NO_BUTTON)
        gen_frame_left = (cmd == gen_last_code) ? REPEAT_UNITS
                                                : full_frame_units(gen_address, cmd);
      gen_last_code = cmd;
    end
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(KIND_TICK, code_t'($urandom_range(0, 255)));
  endtask

  // Hold the sender until every expected result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (unit_results_due.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_address(code_t value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    gen_address = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Ticks and no-button requests while idle send nothing
  task automatic test_idle_items();
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_TICK, 8'hFF);
    send_item(KIND_REQUEST, NO_BUTTON);
    send_item(KIND_REQUEST, NO_BUTTON);
    send_item(KIND_TICK, 8'hA5);
    drain_results();
  endtask

  // Full frame at the address extremes, with requests dropped mid-frame
  task automatic test_full_frame_and_drop();
    write_address(8'h00);
    send_item(KIND_REQUEST, 8'h00);
    send_ticks(20);
    send_item(KIND_REQUEST, 8'h12);
    send_item(KIND_REQUEST, NO_BUTTON);
    send_ticks(gen_frame_left);
    drain_results();
    write_address(8'hFF);
    // back-to-back request right after the trailer unit
    no_gaps = 1'b1;
    send_item(KIND_REQUEST, 8'hFE);
    send_ticks(gen_frame_left);
    send_item(KIND_REQUEST, 8'h01);
    no_gaps = 1'b0;
    send_ticks(gen_frame_left);
    drain_results();
  endtask

  // Same code again gives a repeat frame; no-button in between breaks it
  task automatic test_repeat_frame();
    send_item(KIND_REQUEST, 8'h01);
    send_item(KIND_REQUEST, 8'h77);
    send_ticks(gen_frame_left + 2);
    send_item(KIND_REQUEST, NO_BUTTON);
    send_item(KIND_REQUEST, 8'h01);
    send_ticks(gen_frame_left);
    drain_results();
  endtask

  // Address written during a frame applies only to the next full frame
  task automatic test_address_hold();
    send_item(KIND_REQUEST, 8'h3C);
    drain_results();
    write_address(8'h5A);
    send_ticks(gen_frame_left);
    send_item(KIND_REQUEST, 8'hC3);
    send_ticks(gen_frame_left);
    drain_results();
    write_address(ADDRESS_RESET);
  endtask

  // Random frames, broken frames and noise until the item budget is spent
  task automatic test_random_traffic();
    int next_cfg;
    int pick;
    int len;
    int cut;
    code_t cmd;
    next_cfg = items_sent + CFG_INTERVAL;
    while (items_sent < ITEM_TARGET) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      if (items_sent >= next_cfg) begin
        drain_results();
        pick = $urandom_range(0, 3);
        if (pick == 0)      write_address(8'h00);
        else if (pick == 1) write_address(8'hFF);
        else                write_address(code_t'($urandom_range(0, 255)));
        next_cfg += CFG_INTERVAL;
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        repeat ($urandom_range(1, 6))
          send_item(logic'($urandom_range(0, 1)), code_t'($urandom_range(0, 255)));
      end else begin
        // finish any frame left running by a broken sequence
        send_ticks(gen_frame_left);
        pick = $urandom_range(0, 99);
        if (pick < 35)      cmd = gen_last_code;
        else if (pick < 45) cmd = NO_BUTTON;
        else                cmd = code_t'($urandom_range(0, 255));
        send_item(KIND_REQUEST, cmd);
        len = gen_frame_left;
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
        for (int k = 0; k < cut; k++) begin
          send_item(KIND_TICK, code_t'($urandom_range(0, 255)));
          if ($urandom_range(0, 29) == 0)
            send_item(KIND_REQUEST, code_t'($urandom_range(0, 255)));
        end
      end
    end
    no_gaps = 1'b0;
    drain_results();
  endtask

  // Main sequence
  initial begin
    errors         = 0;
    items_sent     = 0;
    no_gaps        = 1'b0;
    gen_address    = ADDRESS_RESET;
    gen_last_code  = NO_BUTTON;
    gen_frame_left = 0;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.kind     <= KIND_TICK;
    in_ch.command  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_items();
    test_full_frame_and_drop();
    test_repeat_frame();
    test_address_hold();
    test_random_traffic();

    repeat (8) @(posedge clk);
    if (unit_results_due.size() != 0) begin
      $error("%0d expected results never arrived", unit_results_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
